[sv/cas_pkg.sv]
// Shared types and constants for the CIGAR affine scorer.
package cas_pkg;

	localparam int CFG_WIDTH      = 16;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int OP_WIDTH       = 8;
	localparam int OUT_WIDTH      = 32;
	localparam int SCORE_WIDTH_DEF = 32;

	// CIGAR operation bytes (ASCII).
	localparam logic [OP_WIDTH-1:0] OP_MATCH    = 8'h4D; // 'M'
	localparam logic [OP_WIDTH-1:0] OP_EQUAL    = 8'h3D; // '='
	localparam logic [OP_WIDTH-1:0] OP_MISMATCH = 8'h58; // 'X'
	localparam logic [OP_WIDTH-1:0] OP_INS      = 8'h49; // 'I'
	localparam logic [OP_WIDTH-1:0] OP_DEL      = 8'h44; // 'D'
	localparam logic [OP_WIDTH-1:0] OP_NONE     = 8'h20; // ' '

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_MATCH_SCORE    = 3'd0,
		REG_MISMATCH_SCORE = 3'd1,
		REG_GAP_OPEN       = 3'd2,
		REG_GAP_EXTEND     = 3'd3,
		REG_GAP_OPEN_ALT   = 3'd4,
		REG_GAP_EXTEND_ALT = 3'd5,
		REG_DUAL_MODE      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] match_score;
		logic [CFG_WIDTH-1:0] mismatch_score;
		logic [CFG_WIDTH-1:0] gap_open;
		logic [CFG_WIDTH-1:0] gap_extend;
		logic [CFG_WIDTH-1:0] gap_open_alt;
		logic [CFG_WIDTH-1:0] gap_extend_alt;
		logic                 dual_mode;
	} cfg_t;

endpackage

[sv/cas_cfg.sv]
// Configuration register file for the CIGAR affine scorer.
module cas_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [cas_pkg::CFG_IDX_WIDTH-1:0] wr_index,
	input  logic [cas_pkg::CFG_WIDTH-1:0]     wr_data,
	output cas_pkg::cfg_t                     cfg
);
	import cas_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MATCH_SCORE:    cfg_q.match_score    <= wr_data;
				REG_MISMATCH_SCORE: cfg_q.mismatch_score <= wr_data;
				REG_GAP_OPEN:       cfg_q.gap_open       <= wr_data;
				REG_GAP_EXTEND:     cfg_q.gap_extend     <= wr_data;
				REG_GAP_OPEN_ALT:   cfg_q.gap_open_alt   <= wr_data;
				REG_GAP_EXTEND_ALT: cfg_q.gap_extend_alt <= wr_data;
				REG_DUAL_MODE:      cfg_q.dual_mode      <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/cas_update.sv]
// Score state registers and the combinational update for one CIGAR operation.
module cas_update #(
	parameter int SCORE_WIDTH = cas_pkg::SCORE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [cas_pkg::OP_WIDTH-1:0]  op_code,
	input  logic                          last,
	input  cas_pkg::cfg_t                 cfg,
	output logic [cas_pkg::OUT_WIDTH-1:0] final_score
);
	import cas_pkg::*;

	localparam int SW = SCORE_WIDTH;

	// Add a 16-bit signed term, clamping at the signed score bounds.
	function automatic logic signed [SW-1:0] sat_add(
		input logic signed [SW-1:0]        a,
		input logic signed [CFG_WIDTH-1:0] b
	);
		logic signed [SW:0] sum;
		sum = {a[SW-1], a} + {{(SW+1-CFG_WIDTH){b[CFG_WIDTH-1]}}, b};
		if (sum[SW] != sum[SW-1]) begin
			sat_add = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sat_add = sum[SW-1:0];
		end
	endfunction

	logic signed [SW-1:0]  main_q, alt_q;
	logic [OP_WIDTH-1:0]   prev_q;

	logic                  prev_gap, op_gap, gap_start;
	logic signed [SW-1:0]  main_m0, main_m1, alt_m1, main_base, alt_base, best;

	always_comb begin
		prev_gap  = (prev_q == OP_INS) || (prev_q == OP_DEL);
		op_gap    = (op_code == OP_INS) || (op_code == OP_DEL);
		gap_start = (prev_q != op_code);

		// In dual mode, a gap run that ends here keeps the better of the two scores.
		main_m0 = (cfg.dual_mode && prev_gap && gap_start && (alt_q > main_q)) ? alt_q : main_q;

		main_base = gap_start ? sat_add(main_m0, cfg.gap_open) : main_m0;
		alt_base  = gap_start ? sat_add(main_m0, cfg.gap_open_alt) : alt_q;

		main_m1 = main_m0;
		alt_m1  = alt_q;
		case (op_code) inside
			OP_MATCH, OP_EQUAL: main_m1 = sat_add(main_m0, cfg.match_score);
			OP_MISMATCH:        main_m1 = sat_add(main_m0, cfg.mismatch_score);
			OP_INS, OP_DEL: begin
				main_m1 = sat_add(main_base, cfg.gap_extend);
				alt_m1  = sat_add(alt_base, cfg.gap_extend_alt);
			end
			default: ;
		endcase

		// In dual mode, a string that ends in a gap also takes the better score.
		best = (cfg.dual_mode && op_gap && (alt_m1 > main_m1)) ? alt_m1 : main_m1;
	end

	generate
		if (SW < OUT_WIDTH) begin : g_narrow
			assign final_score = {{(OUT_WIDTH-SW){best[SW-1]}}, best};
		end else if (SW == OUT_WIDTH) begin : g_equal
			assign final_score = best;
		end else begin : g_wide
			logic fits;
			assign fits = (best[SW-1:OUT_WIDTH-1] == '0) || (best[SW-1:OUT_WIDTH-1] == '1);
			assign final_score = fits ? best[OUT_WIDTH-1:0]
				: (best[SW-1] ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
				              : {1'b0, {(OUT_WIDTH-1){1'b1}}});
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q <= '0;
			alt_q  <= '0;
			prev_q <= OP_NONE;
		end else if (step) begin
			if (last) begin
				main_q <= '0;
				alt_q  <= '0;
				prev_q <= OP_NONE;
			end else begin
				main_q <= main_m1;
				alt_q  <= alt_m1;
				prev_q <= op_code;
			end
		end
	end

endmodule

[sv/cigar_affine_scorer.sv]
// Top level of the CIGAR affine scorer: input register, score update and result register.
//
//   channel  | valid / ready            | payload
//   ---------+--------------------------+-------------------------------
//   op       | op_valid / op_ready      | op_code[7:0], last
//   score    | score_valid / score_ready| total_score[31:0] (signed)
//   cfg      | cfg_valid / cfg_ready    | cfg_index[2:0], cfg_data[15:0]
//
// One request is taken per cycle. A request is held in the input register while the
// score update runs on it; a last request's total appears on the score channel in
// the following cycle. Only a last request waiting on a full result register stalls
// the input. Reset clears the scores, the register file and all valid flags. The cfg
// channel is always ready.
module cigar_affine_scorer #(
	parameter int SCORE_WIDTH = cas_pkg::SCORE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              op_valid,
	output logic                              op_ready,
	input  logic [cas_pkg::OP_WIDTH-1:0]      op_code,
	input  logic                              last,
	output logic                              score_valid,
	input  logic                              score_ready,
	output logic signed [cas_pkg::OUT_WIDTH-1:0] total_score,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cas_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [cas_pkg::CFG_WIDTH-1:0]     cfg_data
);
	import cas_pkg::*;

	cfg_t                 cfg;
	logic                 valid_s1, last_s1;
	logic [OP_WIDTH-1:0]  op_code_s1;
	logic                 advance, out_free;
	logic [OUT_WIDTH-1:0] final_score;
	logic                 out_valid_q;
	logic [OUT_WIDTH-1:0] total_score_q;

	assign cfg_ready = 1'b1;

	cas_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign out_free = !out_valid_q || score_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign op_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_valid && op_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			op_code_s1 <= op_code;
			last_s1    <= last;
		end
	end

	cas_update #(
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.op_code     (op_code_s1),
		.last        (last_s1),
		.cfg         (cfg),
		.final_score (final_score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (score_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			total_score_q <= final_score;
		end
	end

	assign score_valid = out_valid_q;
	assign total_score = total_score_q;

endmodule

[bench/tb_top.sv]
// Self-checking bench for the CIGAR affine scorer: random strings, register settings and back-pressure.
module tb_top;
	import cas_pkg::*;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
	localparam int PIPE_SETTLE = 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_OPS   = 300;
	localparam int SAT_RUN     = 100;

	typedef struct packed {
		logic [OP_WIDTH-1:0] code;
		logic                is_last;
	} cigar_item_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_mode_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               op_valid = 1'b0;
	logic                               op_ready;
	logic [OP_WIDTH-1:0]                op_code = '0;
	logic                               last = 1'b0;
	logic                               score_valid;
	logic                               score_ready = 1'b0;
	logic signed [OUT_WIDTH-1:0]        total_score;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]           cfg_index = '0;
	logic [CFG_WIDTH-1:0]               cfg_data = '0;

	cigar_affine_scorer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (op_valid),
		.op_ready    (op_ready),
		.op_code     (op_code),
		.last        (last),
		.score_valid (score_valid),
		.score_ready (score_ready),
		.total_score (total_score),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register shadows and scoring state of the predictor.
	logic signed [CFG_WIDTH-1:0] w_match = '0, w_mismatch = '0, w_open = '0, w_extend = '0;
	logic signed [CFG_WIDTH-1:0] w_open_alt = '0, w_extend_alt = '0;
	logic                        dual_on = 1'b0;
	logic signed [OUT_WIDTH-1:0] main_sc = '0, alt_sc = '0;
	logic [OP_WIDTH-1:0]         prev_op = OP_NONE;

	cigar_item_t                 op_backlog[$];
	logic signed [OUT_WIDTH-1:0] totals_due[$];

	int unsigned ops_queued = 0, ops_accepted = 0, strings_scored = 0, cfg_writes = 0;
	int unsigned mismatch_count = 0, quiet_cycles = 0;
	logic        hold_sender = 1'b0;

	function automatic logic signed [OUT_WIDTH-1:0] clamp_add(input logic signed [OUT_WIDTH-1:0] acc,
			input logic signed [CFG_WIDTH-1:0] w);
		longint s;
		s = longint'(acc) + longint'(w);
		if (s > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (s < -64'sd2147483648)
			return 32'sh8000_0000;
		return s[OUT_WIDTH-1:0];
	endfunction

	function automatic logic is_gap_op(input logic [OP_WIDTH-1:0] c);
		return c == OP_INS || c == OP_DEL;
	endfunction

	// Advances the score by one operation and, at the end of a string, records its total.
	function automatic void score_cigar_op(input logic [OP_WIDTH-1:0] c, input logic fin);
		if (dual_on && is_gap_op(prev_op) && c != prev_op && alt_sc > main_sc)
			main_sc = alt_sc;
		if (c == OP_MATCH || c == OP_EQUAL) begin
			main_sc = clamp_add(main_sc, w_match);
		end else if (c == OP_MISMATCH) begin
			main_sc = clamp_add(main_sc, w_mismatch);
		end else if (is_gap_op(c)) begin
			if (prev_op != c) begin
				alt_sc = clamp_add(main_sc, w_open_alt);
				main_sc = clamp_add(main_sc, w_open);
			end
			main_sc = clamp_add(main_sc, w_extend);
			alt_sc = clamp_add(alt_sc, w_extend_alt);
		end
		prev_op = c;
		if (fin) begin
			if (dual_on && is_gap_op(c) && alt_sc > main_sc)
				main_sc = alt_sc;
			totals_due.push_back(main_sc);
			main_sc = '0;
			alt_sc = '0;
			prev_op = OP_NONE;
		end
	endfunction

	// Sender: bursts of random length separated by short random gaps.
	int unsigned burst_left = 1, gap_left = 0;
	cigar_item_t next_op;

	always @(posedge clk) begin
		if (!arst_n) begin
			op_valid <= 1'b0;
		end else begin
			if (op_valid && op_ready) begin
				score_cigar_op(op_code, last);
				ops_accepted++;
				if (last)
					strings_scored++;
			end
			if (!op_valid || op_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					op_valid <= 1'b0;
				end else if (!hold_sender && op_backlog.size() != 0) begin
					next_op = op_backlog.pop_front();
					op_valid <= 1'b1;
					op_code <= next_op.code;
					last <= next_op.is_last;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					op_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each total and stalls according to a mode that changes now and then.
	rx_mode_t                    rx_mode = RX_OPEN;
	int unsigned                 rx_mode_left = 0;
	logic [1:0]                  rx_tick = '0;
	logic signed [OUT_WIDTH-1:0] want_total;

	always @(posedge clk) begin
		if (!arst_n) begin
			score_ready <= 1'b0;
		end else begin
			if (score_valid && score_ready) begin
				if (totals_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected total_score %0d with no string outstanding",
							total_score);
					mismatch_count++;
				end else begin
					want_total = totals_due.pop_front();
					if (total_score !== want_total) begin
						if (mismatch_count < 10)
							$display("total_score mismatch: expected %0d, got %0d",
								want_total, total_score);
						mismatch_count++;
					end
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(50, 400);
			end else begin
				rx_mode_left--;
			end
			rx_tick++;
			case (rx_mode)
				RX_OPEN:    score_ready <= 1'b1;
				RX_COIN:    score_ready <= 1'($urandom_range(0, 1));
				RX_QUARTER: score_ready <= (rx_tick == 2'b11);
				default:    score_ready <= ($urandom_range(0, 19) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((op_valid && op_ready) || (score_valid && score_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAIL cigar_affine_scorer");
				$finish;
			end
		end
	end

	// Called just after a rising edge; leaves cfg_valid high so that writes can follow back to back.
	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_MATCH_SCORE:    w_match = value;
			REG_MISMATCH_SCORE: w_mismatch = value;
			REG_GAP_OPEN:       w_open = value;
			REG_GAP_EXTEND:     w_extend = value;
			REG_GAP_OPEN_ALT:   w_open_alt = value;
			REG_GAP_EXTEND_ALT: w_extend_alt = value;
			REG_DUAL_MODE:      dual_on = value[0];
			default:            ;
		endcase
		cfg_writes++;
	endtask

	task automatic load_weights(input logic [CFG_WIDTH-1:0] m, x, o, e, oa, ea, input logic d);
		write_reg(REG_MATCH_SCORE, m);
		write_reg(REG_MISMATCH_SCORE, x);
		write_reg(REG_GAP_OPEN, o);
		write_reg(REG_GAP_EXTEND, e);
		write_reg(REG_GAP_OPEN_ALT, oa);
		write_reg(REG_GAP_EXTEND_ALT, ea);
		write_reg(REG_DUAL_MODE, {15'($urandom_range(0, 32767)), d});
		// The spare index must leave every register untouched.
		write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_op(input logic [OP_WIDTH-1:0] c, input logic fin);
		cigar_item_t it;
		it.code = c;
		it.is_last = fin;
		op_backlog.push_back(it);
		ops_queued++;
	endtask

	// Mostly real operations with gap runs, plus the odd arbitrary byte.
	task automatic queue_string(input int unsigned len);
		int unsigned k, pick, run_left;
		logic [OP_WIDTH-1:0] c, run_op;
		run_left = 0;
		run_op = OP_INS;
		for (k = 0; k < len; k++) begin
			if (run_left != 0) begin
				c = run_op;
				run_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 25)
					c = OP_MATCH;
				else if (pick < 35)
					c = OP_EQUAL;
				else if (pick < 50)
					c = OP_MISMATCH;
				else if (pick < 68)
					c = OP_INS;
				else if (pick < 86)
					c = OP_DEL;
				else
					c = 8'($urandom_range(0, 255));
				if (is_gap_op(c)) begin
					run_op = c;
					run_left = $urandom_range(0, 5);
				end
			end
			queue_op(c, k == len - 1);
		end
	endtask

	// Waits until every operation is in and every total is out, then lets the pipeline settle.
	task automatic drain();
		while (ops_accepted != ops_queued || totals_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned phase, k, phase_end, phase_mid;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset value score everything as zero.
		queue_op(OP_MATCH, 1'b0);
		queue_op(OP_INS, 1'b1);
		drain();

		// Small weights so that the best-of-two choice goes both ways.
		load_weights(16'sd5, -16'sd3, -16'sd10, -16'sd1, -16'sd4, -16'sd3, 1'b1);
		queue_op(OP_MATCH, 1'b0);
		queue_op(OP_EQUAL, 1'b0);
		queue_op(OP_MISMATCH, 1'b0);
		queue_op(OP_INS, 1'b0);
		queue_op(OP_DEL, 1'b0);
		queue_op(OP_DEL, 1'b0);
		queue_op(8'h00, 1'b0);
		queue_op(OP_MATCH, 1'b1);
		for (k = 0; k < 7; k++)
			queue_op(OP_INS, 1'b0);
		queue_op(8'hFF, 1'b0);
		queue_op(OP_DEL, 1'b0);
		queue_op(OP_INS, 1'b1);
		queue_op(OP_MATCH, 1'b1);
		queue_op(8'h80, 1'b1);
		queue_op(OP_DEL, 1'b1);
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_weights(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
				1: load_weights(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
				2: load_weights(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
				3: load_weights(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
				4: load_weights(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 1'b1);
				default: load_weights(16'($urandom_range(0, 15)), 16'(-$urandom_range(0, 15)),
					16'(-$urandom_range(0, 40)), 16'(-$urandom_range(0, 8)),
					16'(-$urandom_range(0, 40)), 16'(-$urandom_range(0, 8)), 1'b1);
			endcase
			phase_mid = ops_queued + PHASE_OPS / 2;
			phase_end = ops_queued + PHASE_OPS;
			while (ops_queued < phase_end)
				queue_string(($urandom_range(0, 7) == 0) ? $urandom_range(17, 60)
					: $urandom_range(1, 16));
			if (phase == 0) begin
				// Hold the sender half way until every outstanding total has been returned.
				while (ops_accepted < phase_mid)
					@(posedge clk);
				hold_sender <= 1'b1;
				@(posedge clk);
				while (op_valid || totals_due.size() != 0)
					@(posedge clk);
				repeat (5) @(posedge clk);
				hold_sender <= 1'b0;
			end
			drain();
		end

		// Alternating gap runs at extreme weights push the score hard in both directions.
		load_weights(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		for (k = 0; k < SAT_RUN; k++)
			queue_op(k[0] ? OP_DEL : OP_INS, 1'b0);
		queue_op(OP_MATCH, 1'b1);
		queue_string(20);
		drain();
		load_weights(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		for (k = 0; k < SAT_RUN; k++)
			queue_op(k[0] ? OP_INS : OP_DEL, 1'b0);
		queue_op(OP_DEL, 1'b1);
		queue_string(20);
		drain();

		$display("Scored %0d CIGAR strings from %0d operations after %0d register writes,",
			strings_scored, ops_accepted, cfg_writes);
		$display("with dual mode on and off, extreme weights and long alternating gap runs.");
		if (mismatch_count == 0 && totals_due.size() == 0)
			$display("PASS cigar_affine_scorer");
		else
			$display("FAIL cigar_affine_scorer");
		$finish;
	end

endmodule
